[design/cgl_pkg.sv]
// Shared constants, field layout and types for the code point to glyph lookup.
`timescale 1ns / 1ps
package cgl_pkg;

   // Table and cache sizes
   localparam int MAX_INTERVALS = 4096;
   localparam int CACHE_LINES   = 64;   // power of two: the line is the low code point bits
   localparam int IDX_W         = $clog2(MAX_INTERVALS);
   localparam int CNT_W         = IDX_W + 1;
   localparam int LINE_W        = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;

   // Field widths
   localparam int SLOT_W  = 12;
   localparam int CP_W    = 21;
   localparam int GLYPH_W = 18;
   localparam int ICNT_W  = 13;
   localparam int GCNT_W  = 18;
   localparam int IDX_SUM_W = ((CP_W > GLYPH_W) ? CP_W : GLYPH_W) + 1;

   // Request tdata layout, lowest field first
   localparam int SLOT_LSB   = 0;
   localparam int FIRST_LSB  = SLOT_LSB + SLOT_W;
   localparam int LAST_LSB   = FIRST_LSB + CP_W;
   localparam int BASE_LSB   = LAST_LSB + CP_W;
   localparam int CP_LSB     = BASE_LSB + GLYPH_W;
   localparam int REQ_FIELDS_W = CP_LSB + CP_W;
   localparam int REQ_DATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;

   // Response tdata layout: found, then glyph number
   localparam int RSP_FIELDS_W = 1 + GLYPH_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = GCNT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_LOADED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_COUNT    = 2'd2;

   // Request kinds
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // One interval table entry
   typedef struct packed {
      logic [GLYPH_W-1:0] base;
      logic [CP_W-1:0]    last;
      logic [CP_W-1:0]    first;
   } ival_type;

   // One cache line payload
   typedef struct packed {
      logic [CP_W-1:0]    tag;
      logic [GLYPH_W-1:0] glyph;
   } cline_type;

endpackage

[design/codepoint_glyph_lookup_core.sv]
// Code point to glyph lookup: interval table, binary search and direct-mapped cache.
`timescale 1ns / 1ps
// Usage
//   req channel: a write item (tuser 0) stores one interval entry at entry_slot and
//   clears the cache; a lookup item (tuser 1) asks for the glyph of code_point.
//   rsp channel: one transfer per lookup (found, glyph number, from-cache flag);
//   write items give no response.
//   csr port: font_loaded, interval_count and glyph_count; a write to any of these clears the cache.
//   Write registers only while the block is idle.
// Sequence
//   A write item leaves the block idle. A lookup goes to the tag check, or to
//   done when no font is loaded; a hit or an empty table then ends it, and a miss
//   probes the interval memory and, on a match, checks the glyph count. There are
//   at most log2(count) + 1 probes, 13 for 4096 entries, each one read of the
//   synchronous interval memory plus compare. One item is in work at a time.
// Reset and stalls
//   Synchronous reset clears the state, configuration and valid registers; the
//   interval memory is undefined until written. A stalled response is held in
//   the output register; the next item is still taken and waits for it to free.
module codepoint_glyph_lookup_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // entry_slot, range_first, range_last, glyph_base, code_point, zero pad
   input  logic [cgl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cmd
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // found, glyph_number, zero pad
   output logic [cgl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // from_cache
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [cgl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cgl_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cgl_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TAGCHK = 3'd1;
   localparam logic [2:0] ST_PROBE  = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   // Request fields
   logic                req_cmd;
   logic [SLOT_W-1:0]   req_slot;
   logic [CP_W-1:0]     req_first;
   logic [CP_W-1:0]     req_last;
   logic [GLYPH_W-1:0]  req_base;
   logic [CP_W-1:0]     req_cp;
   logic [LINE_W-1:0]   req_line;
   logic                req_xfer;

   // Configuration
   logic                font_ff;
   logic [ICNT_W-1:0]   icount_ff;
   logic [GCNT_W-1:0]   gcount_ff;
   logic [CNT_W-1:0]    count;
   logic                csr_hit;

   // Memories
   ival_type            imem [MAX_INTERVALS];
   ival_type            ent_ff;
   cline_type           cmem [CACHE_LINES];
   cline_type           cline_ff;
   logic [CACHE_LINES-1:0] cvalid_ff;
   logic                cache_wr;
   logic                cache_clr;

   // Search control
   logic [2:0]          state_ff, state_in;
   logic [CP_W-1:0]     cp_ff, cp_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [IDX_W-1:0]    mid_ff, mid_in;
   logic [IDX_SUM_W-1:0] idx_ff, idx_in;
   logic                res_found_ff, res_found_in;
   logic [GLYPH_W-1:0]  res_glyph_ff, res_glyph_in;
   logic                res_cache_ff, res_cache_in;

   // Output register
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [GLYPH_W-1:0]  rsp_glyph_ff;
   logic                rsp_cache_ff;
   logic                rsp_load;

   // Midpoint of the half-open range [lo, hi)
   function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                               input logic [CNT_W-1:0] hi);
      logic [CNT_W:0] sum;
      sum = {1'b0, lo} + {1'b0, hi} - {{CNT_W{1'b0}}, 1'b1};
      return sum[IDX_W:1];
   endfunction

   // Unpack the request
   assign req_cmd   = req_tuser;
   assign req_slot  = req_tdata[SLOT_LSB +: SLOT_W];
   assign req_first = req_tdata[FIRST_LSB +: CP_W];
   assign req_last  = req_tdata[LAST_LSB +: CP_W];
   assign req_base  = req_tdata[BASE_LSB +: GLYPH_W];
   assign req_cp    = req_tdata[CP_LSB +: CP_W];
   assign req_line  = req_cp[LINE_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // Drive the response
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_glyph_ff, rsp_found_ff};
   assign rsp_tuser  = rsp_cache_ff;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Clamp the searched count to the table depth
   always_comb begin
      if (32'(icount_ff) > 32'(MAX_INTERVALS)) begin
         count = CNT_W'(MAX_INTERVALS);
      end else begin
         count = CNT_W'(icount_ff);
      end
   end

   // Decode register writes that clear the cache
   always_comb begin
      csr_hit = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_FONT_LOADED, CSR_INTERVAL_COUNT, CSR_GLYPH_COUNT: csr_hit = 1'b1;
            default: csr_hit = 1'b0;
         endcase
      end
   end

   assign cache_clr = csr_hit || (req_xfer && req_cmd == CMD_WRITE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         font_ff   <= 1'b0;
         icount_ff <= '0;
         gcount_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FONT_LOADED:    font_ff   <= csr_wdata[0];
            CSR_INTERVAL_COUNT: icount_ff <= csr_wdata[ICNT_W-1:0];
            CSR_GLYPH_COUNT:    gcount_ff <= csr_wdata[GCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Interval memory: write on a write item, read the next probe every cycle
   always_ff @(posedge clock) begin
      if (req_xfer && req_cmd == CMD_WRITE && 32'(req_slot) < 32'(MAX_INTERVALS)) begin
         imem[IDX_W'(req_slot)] <= '{base: req_base, last: req_last, first: req_first};
      end
      ent_ff <= imem[mid_in];
   end

   // Cache memory: read the line of the incoming code point, fill on a valid miss
   always_ff @(posedge clock) begin
      if (cache_wr) begin
         cmem[line_ff] <= '{tag: cp_ff, glyph: idx_ff[GLYPH_W-1:0]};
      end
      cline_ff <= cmem[req_line];
   end

   // Cache valid bits
   always_ff @(posedge clock) begin
      if (reset || cache_clr) begin
         cvalid_ff <= '0;
      end else if (cache_wr) begin
         cvalid_ff[line_ff] <= 1'b1;
      end
   end

   // Lookup sequencer
   always_comb begin
      state_in     = state_ff;
      cp_in        = cp_ff;
      line_in      = line_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      idx_in       = idx_ff;
      res_found_in = res_found_ff;
      res_glyph_in = res_glyph_ff;
      res_cache_in = res_cache_ff;
      cache_wr     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_cmd == CMD_LOOKUP) begin
               cp_in        = req_cp;
               line_in      = req_line;
               res_found_in = 1'b0;
               res_glyph_in = '0;
               res_cache_in = 1'b0;
               state_in     = font_ff ? ST_TAGCHK : ST_DONE;
            end
         end

         ST_TAGCHK: begin
            if (cvalid_ff[line_ff] && cline_ff.tag == cp_ff) begin
               res_found_in = 1'b1;
               res_glyph_in = cline_ff.glyph;
               res_cache_in = 1'b1;
               state_in     = ST_DONE;
            end else if (count == '0) begin
               state_in = ST_DONE;
            end else begin
               // start the search over [0, count)
               lo_in    = '0;
               hi_in    = count;
               mid_in   = mid_of('0, count);
               state_in = ST_PROBE;
            end
         end

         ST_PROBE: begin
            if (cp_ff < ent_ff.first) begin
               hi_in = {1'b0, mid_ff};
            end else if (cp_ff > ent_ff.last) begin
               lo_in = {1'b0, mid_ff} + {{IDX_W{1'b0}}, 1'b1};
            end else begin
               idx_in   = IDX_SUM_W'(ent_ff.base) + IDX_SUM_W'(cp_ff - ent_ff.first);
               state_in = ST_CHECK;
            end
            // narrow the range and issue the next probe, or give up
            if (state_in == ST_PROBE) begin
               if (lo_in >= hi_in) begin
                  state_in = ST_DONE;
               end else begin
                  mid_in = mid_of(lo_in, hi_in);
               end
            end
         end

         ST_CHECK: begin
            if (idx_ff < IDX_SUM_W'(gcount_ff)) begin
               res_found_in = 1'b1;
               res_glyph_in = idx_ff[GLYPH_W-1:0];
               cache_wr     = 1'b1;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cp_ff        <= cp_in;
      line_ff      <= line_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      idx_ff       <= idx_in;
      res_found_ff <= res_found_in;
      res_glyph_ff <= res_glyph_in;
      res_cache_ff <= res_cache_in;
   end

   // Output register: load a finished result, drop it after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_glyph_ff <= res_glyph_ff;
         rsp_cache_ff <= res_cache_ff;
      end
   end

endmodule
